FILE: rtl/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg: shared types and constants of the linear sieve Mobius table
// Widths, operation and status codes, and the bundles between the
// sequencer and the table store.
// ----------------------------------------------------------------------------
package lsm_pkg;

    localparam int NUM_W     = 16;
    localparam int CNT_W     = 13;
    localparam int MAX_PRIMES = 8192;
    localparam int PIDX_W    = $clog2(MAX_PRIMES);
    localparam int PTOT_W    = PIDX_W + 1;
    localparam int TBL_DEPTH = 1 << NUM_W;
    localparam logic [NUM_W-1:0] MAX_LIMIT = 16'hFFFF;
    localparam logic [NUM_W-1:0] MIN_LIMIT = 16'd2;

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT  = 2'd1;
    localparam logic [1:0] ST_PAST_LIMIT = 2'd2;

    localparam logic [1:0] MOB_ZERO = 2'b00;
    localparam logic [1:0] MOB_ONE  = 2'b01;
    localparam logic [1:0] MOB_NEG  = 2'b11;

    typedef struct packed {
        logic              tbl_we;
        logic              pfx_we;
        logic [NUM_W-1:0]  wr_addr;
        logic [NUM_W-1:0]  spf_d;
        logic [NUM_W-1:0]  lpf_d;
        logic [1:0]        mob_d;
        logic [CNT_W-1:0]  pfx_d;
        logic [NUM_W-1:0]  tbl_rd_addr;
        logic [NUM_W-1:0]  pfx_rd_a;
        logic [NUM_W-1:0]  pfx_rd_b;
        logic              list_we;
        logic [PIDX_W-1:0] list_wr_addr;
        logic [NUM_W-1:0]  list_d;
        logic [PIDX_W-1:0] list_rd_addr;
    } mem_cmd_t;

    typedef struct packed {
        logic [NUM_W-1:0] spf_q;
        logic [NUM_W-1:0] lpf_q;
        logic [1:0]       mob_q;
        logic [CNT_W-1:0] pfx_a_q;
        logic [CNT_W-1:0] pfx_b_q;
        logic [NUM_W-1:0] list_q;
    } mem_rsp_t;

endpackage

FILE: rtl/lsm_store.sv
// ----------------------------------------------------------------------------
// lsm_store: table memories of the sieve
// Smallest factor, largest factor, Mobius and prime prefix tables, and the
// list of primes. One write port each, registered reads.
// ----------------------------------------------------------------------------
module lsm_store (
    input  logic              clk,
    input  lsm_pkg::mem_cmd_t cmd,
    output lsm_pkg::mem_rsp_t rsp
);
    import lsm_pkg::*;

    logic [NUM_W-1:0] spf_mem  [0:TBL_DEPTH-1];
    logic [NUM_W-1:0] lpf_mem  [0:TBL_DEPTH-1];
    logic [1:0]       mob_mem  [0:TBL_DEPTH-1];
    logic [CNT_W-1:0] pfx_mem  [0:TBL_DEPTH-1];
    logic [NUM_W-1:0] list_mem [0:MAX_PRIMES-1];

    always_ff @(posedge clk)
    begin
        if (cmd.tbl_we)
        begin
            spf_mem[cmd.wr_addr] <= cmd.spf_d;
            lpf_mem[cmd.wr_addr] <= cmd.lpf_d;
            mob_mem[cmd.wr_addr] <= cmd.mob_d;
        end
        if (cmd.pfx_we)
        begin
            pfx_mem[cmd.wr_addr] <= cmd.pfx_d;
        end
        if (cmd.list_we)
        begin
            list_mem[cmd.list_wr_addr] <= cmd.list_d;
        end
        rsp.spf_q   <= spf_mem[cmd.tbl_rd_addr];
        rsp.lpf_q   <= lpf_mem[cmd.tbl_rd_addr];
        rsp.mob_q   <= mob_mem[cmd.tbl_rd_addr];
        rsp.pfx_a_q <= pfx_mem[cmd.pfx_rd_a];
        rsp.pfx_b_q <= pfx_mem[cmd.pfx_rd_b];
        rsp.list_q  <= list_mem[cmd.list_rd_addr];
    end

endmodule

FILE: rtl/lsm_ctrl.sv
// ----------------------------------------------------------------------------
// lsm_ctrl: sieve sequencer
// Clears the tables, walks the linear sieve with one shared multiplier and
// compare, serves queries, and holds the result register.
// ----------------------------------------------------------------------------
module lsm_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_op,
    input  logic [lsm_pkg::NUM_W-1:0] in_number,
    input  logic [lsm_pkg::NUM_W-1:0] in_low,
    input  logic [lsm_pkg::NUM_W-1:0] in_high,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lsm_pkg::NUM_W-1:0] cfg_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                out_mobius,
    output logic [lsm_pkg::NUM_W-1:0] out_largest,
    output logic [lsm_pkg::CNT_W-1:0] out_count,
    output logic [1:0]                out_status,
    output lsm_pkg::mem_cmd_t         cmd,
    input  lsm_pkg::mem_rsp_t         rsp
);
    import lsm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_RDI  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_PRD  = 3'd4;
    localparam logic [2:0] S_PCHK = 3'd5;
    localparam logic [2:0] S_QRD  = 3'd6;
    localparam logic [2:0] S_QOUT = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [NUM_W-1:0]  limit_cfg_reg, limit_cfg_next;
    logic [NUM_W-1:0]  lim_reg, lim_next;
    logic [NUM_W-1:0]  built_lim_reg, built_lim_next;
    logic              built_reg, built_next;
    logic [NUM_W-1:0]  i_reg, i_next;
    logic [PTOT_W-1:0] k_reg, k_next;
    logic [PTOT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [NUM_W-1:0]  cur_spf_reg, cur_spf_next;
    logic [NUM_W-1:0]  cur_lpf_reg, cur_lpf_next;
    logic [1:0]        cur_mob_reg, cur_mob_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  lo_reg, lo_next;
    logic [NUM_W-1:0]  hi_reg, hi_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_mob_reg, out_mob_next;
    logic [NUM_W-1:0]  out_lpf_reg, out_lpf_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [1:0]        out_st_reg, out_st_next;

    logic              accept;
    logic              row_unmarked;
    logic              last_i;
    logic [2*NUM_W-1:0] product;
    logic [NUM_W-1:0]  p;

    assign accept       = in_valid && in_ready;
    assign in_ready     = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready    = 1'b1;
    assign row_unmarked = (rsp.spf_q == '0);
    assign last_i       = (i_reg == lim_reg);
    assign p            = rsp.list_q;
    assign product      = {{NUM_W{1'b0}}, i_reg} * {{NUM_W{1'b0}}, p};

    assign out_valid   = out_valid_reg;
    assign out_mobius  = out_mob_reg;
    assign out_largest = out_lpf_reg;
    assign out_count   = out_cnt_reg;
    assign out_status  = out_st_reg;

    always_comb
    begin
        state_next     = state_reg;
        limit_cfg_next = limit_cfg_reg;
        lim_next       = lim_reg;
        built_lim_next = built_lim_reg;
        built_next     = built_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        total_next     = total_reg;
        run_next       = run_reg;
        cur_spf_next   = cur_spf_reg;
        cur_lpf_next   = cur_lpf_reg;
        cur_mob_next   = cur_mob_reg;
        num_next       = num_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_mob_next   = out_mob_reg;
        out_lpf_next   = out_lpf_reg;
        out_cnt_next   = out_cnt_reg;
        out_st_next    = out_st_reg;

        cmd              = '0;
        cmd.tbl_rd_addr  = i_reg;
        cmd.pfx_rd_a     = hi_reg;
        cmd.pfx_rd_b     = lo_reg;
        cmd.list_rd_addr = k_reg[PIDX_W-1:0];

        if (cfg_valid && cfg_ready)
        begin
            limit_cfg_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_BUILD)
                    begin
                        priority if (limit_cfg_reg < MIN_LIMIT)
                            lim_next = MIN_LIMIT;
                        else if (limit_cfg_reg > MAX_LIMIT)
                            lim_next = MAX_LIMIT;
                        else
                            lim_next = limit_cfg_reg;
                        i_next     = '0;
                        total_next = '0;
                        run_next   = '0;
                        state_next = S_CLR;
                    end
                    else if (!built_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_mob_next   = MOB_ZERO;
                        out_lpf_next   = '0;
                        out_cnt_next   = '0;
                        out_st_next    = ST_NOT_BUILT;
                    end
                    else
                    begin
                        num_next   = in_number;
                        lo_next    = (in_low > built_lim_reg) ? built_lim_reg : in_low;
                        hi_next    = (in_high > built_lim_reg) ? built_lim_reg : in_high;
                        state_next = S_QRD;
                    end
                end
            end
            S_CLR:
            begin
                // Clear every row up to the limit, largest factor to 1; one starts as squarefree.
                cmd.tbl_we  = 1'b1;
                cmd.pfx_we  = 1'b1;
                cmd.wr_addr = i_reg;
                cmd.spf_d   = '0;
                cmd.lpf_d   = NUM_W'(1);
                cmd.mob_d   = (i_reg == NUM_W'(1)) ? MOB_ONE : MOB_ZERO;
                cmd.pfx_d   = '0;
                if (last_i)
                begin
                    i_next     = MIN_LIMIT;
                    state_next = S_RDI;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_RDI:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.pfx_we  = 1'b1;
                cmd.wr_addr = i_reg;
                cmd.pfx_d   = run_reg + CNT_W'(row_unmarked);
                run_next    = run_reg + CNT_W'(row_unmarked);
                k_next      = '0;
                if (row_unmarked)
                begin
                    cmd.tbl_we   = 1'b1;
                    cmd.spf_d    = i_reg;
                    cmd.lpf_d    = i_reg;
                    cmd.mob_d    = MOB_NEG;
                    cur_spf_next = i_reg;
                    cur_lpf_next = i_reg;
                    cur_mob_next = MOB_NEG;
                    if (total_reg < PTOT_W'(MAX_PRIMES))
                    begin
                        cmd.list_we      = 1'b1;
                        cmd.list_wr_addr = total_reg[PIDX_W-1:0];
                        cmd.list_d       = i_reg;
                        total_next       = total_reg + 1'b1;
                    end
                end
                else
                begin
                    cur_spf_next = rsp.spf_q;
                    cur_lpf_next = rsp.lpf_q;
                    cur_mob_next = rsp.mob_q;
                end
                state_next = S_PRD;
            end
            S_PRD:
            begin
                if (k_reg < total_reg)
                begin
                    state_next = S_PCHK;
                end
                else if (last_i)
                begin
                    built_next     = 1'b1;
                    built_lim_next = lim_reg;
                    out_valid_next = 1'b1;
                    out_mob_next   = MOB_ZERO;
                    out_lpf_next   = '0;
                    out_cnt_next   = '0;
                    out_st_next    = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RDI;
                end
            end
            S_PCHK:
            begin
                if (product > {{NUM_W{1'b0}}, lim_reg})
                begin
                    // Force the prime walk to end: S_PRD then moves to the next i, or ends the build after the last i.
                    k_next     = total_reg;
                    state_next = S_PRD;
                end
                else
                begin
                    cmd.tbl_we  = 1'b1;
                    cmd.wr_addr = product[NUM_W-1:0];
                    cmd.spf_d   = p;
                    cmd.lpf_d   = (cur_lpf_reg > p) ? cur_lpf_reg : p;
                    // p divides i exactly when p is the smallest factor of i.
                    if (p == cur_spf_reg)
                    begin
                        cmd.mob_d = MOB_ZERO;
                        k_next    = total_reg;
                    end
                    else
                    begin
                        cmd.mob_d = 2'(-cur_mob_reg);
                        k_next    = k_reg + 1'b1;
                    end
                    state_next = S_PRD;
                end
            end
            S_QRD:
            begin
                cmd.tbl_rd_addr = num_reg;
                state_next      = S_QOUT;
            end
            S_QOUT:
            begin
                out_valid_next = 1'b1;
                out_cnt_next   = (hi_reg <= lo_reg) ? '0 : rsp.pfx_a_q - rsp.pfx_b_q;
                if (num_reg > built_lim_reg)
                begin
                    out_mob_next = MOB_ZERO;
                    out_lpf_next = '0;
                    out_st_next  = ST_PAST_LIMIT;
                end
                else
                begin
                    out_mob_next = rsp.mob_q;
                    out_lpf_next = rsp.lpf_q;
                    out_st_next  = ST_OK;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_cfg_reg <= MAX_LIMIT;
            built_reg     <= 1'b0;
            built_lim_reg <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_cfg_reg <= limit_cfg_next;
            built_reg     <= built_next;
            built_lim_reg <= built_lim_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg     <= lim_next;
        i_reg       <= i_next;
        k_reg       <= k_next;
        run_reg     <= run_next;
        cur_spf_reg <= cur_spf_next;
        cur_lpf_reg <= cur_lpf_next;
        cur_mob_reg <= cur_mob_next;
        num_reg     <= num_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        out_mob_reg <= out_mob_next;
        out_lpf_reg <= out_lpf_next;
        out_cnt_reg <= out_cnt_next;
        out_st_reg  <= out_st_next;
    end

endmodule

FILE: rtl/linear_sieve_mobius_table.sv
// Query: the request passes S_QRD, S_QOUT and the result register; one item at a time.
// Query before a build: the result shows in the cycle after the transfer.
// Build: table clearing of rows 0 to L, then per number S_RDI, S_CHK and S_PRD, plus
// S_PCHK and S_PRD per prime tried, all through the one multiplier and the table store ports.
// Reset clears the control state and the built flag and sets the limit to 65535;
// table contents are undefined until a build writes them.
// ----------------------------------------------------------------------------
// linear_sieve_mobius_table: linear sieve with Mobius and prime count tables
// Builds the tables on request and answers Mobius, largest factor and
// interval prime count queries.
// ----------------------------------------------------------------------------
module linear_sieve_mobius_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // number, range_low, range_high
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // mobius_value, largest_factor, interval_primes, status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // sieve_limit
);
    import lsm_pkg::*;

    mem_cmd_t         cmd;
    mem_rsp_t         rsp;
    logic [1:0]       out_mobius;
    logic [NUM_W-1:0] out_largest;
    logic [CNT_W-1:0] out_count;
    logic [1:0]       out_status;

    lsm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_number   (s_tdata[15:0]),
        .in_low      (s_tdata[31:16]),
        .in_high     (s_tdata[47:32]),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_mobius  (out_mobius),
        .out_largest (out_largest),
        .out_count   (out_count),
        .out_status  (out_status),
        .cmd         (cmd),
        .rsp         (rsp)
    );

    lsm_store u_store (
        .clk (clk),
        .cmd (cmd),
        .rsp (rsp)
    );

    assign m_tdata = {7'b0, out_status, out_count, out_largest, out_mobius};

endmodule

FILE: rtl/lsm_check.sv
// ----------------------------------------------------------------------------
// lsm_check: port-level checks of the sieve table
// Handshake and one-item-at-a-time behavior seen from the ports.
// ----------------------------------------------------------------------------
module lsm_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result waits");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[32:31] != 2'd3)
        else $error("undefined status code");

endmodule

bind linear_sieve_mobius_table lsm_check u_lsm_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
